@@ rtl/core/dvru_pkg.sv @@
// Shared widths, codes and defaults of the distance-vector route update unit.
package dvru_pkg;

    localparam int DVRU_MAX_NODES = 16;

    localparam int ID_W      = 4;
    localparam int CNT_W     = 5;
    localparam int COST_W    = 16;
    localparam int CFG_W     = 5;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_SELF_ID    = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b1;

    localparam logic FUNC_LINK   = 1'b0;
    localparam logic FUNC_VECTOR = 1'b1;

    localparam logic [COST_W-1:0] COST_UNREACH = '1;
    localparam logic [COST_W-2:0] COST_SAT     = '1;

endpackage

@@ rtl/core/distance_vector_route_update_unit.sv @@
// Top level of the distance-vector route update unit: cost memories and relaxation sequencer.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+----------------------------------------------------
//   config   | cfg_write              | cfg_index, cfg_data
//   item in  | start & !busy          | func, source_node, target_node, cost, last_element
//   route out| result_valid (1 cycle) | dest_node, distance, next_hop, advertise, last_route
//
// A cost write (func 0, or func 1 without last_element) leaves busy low.
// A last element starts a run: each heard neighbor row below n, other than the own row, is
// relaxed element by element; other rows are skipped. Then n route entries leave one per cycle.
// Each element is read through the single read port of each cost table copy.
// Reset clears the control state, the heard flags and the next-hop valid flags; the cost
// memories are not cleared. Route entries cannot be stalled by the receiver.
module distance_vector_route_update_unit #(
    parameter int MAX_NODES = dvru_pkg::DVRU_MAX_NODES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [dvru_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [dvru_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic [dvru_pkg::ID_W-1:0]           source_node,
    input  logic [dvru_pkg::ID_W-1:0]           target_node,
    input  logic signed [dvru_pkg::COST_W-1:0]  cost,
    input  logic                                last_element,
    output logic                                result_valid,
    output logic [dvru_pkg::ID_W-1:0]           dest_node,
    output logic signed [dvru_pkg::COST_W-1:0]  distance,
    output logic [dvru_pkg::ID_W-1:0]           next_hop,
    output logic                                advertise,
    output logic                                last_route
);

    import dvru_pkg::*;

    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int N_LIM     = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int TBL_AW    = 2 * IDX_W;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROW   = 3'd1;
    localparam logic [2:0] S_DI    = 3'd2;
    localparam logic [2:0] S_COL   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]           state_reg,  state_next;
    logic [CNT_W-1:0]     i_reg,      i_next;
    logic [CNT_W-1:0]     j_reg,      j_next;
    logic [CNT_W-1:0]     p_j_reg,    p_j_next;
    logic                 p_vld_reg,  p_vld_next;
    logic                 p_out_reg,  p_out_next;
    logic [COST_W-2:0]    di_reg,     di_next;
    logic                 change_reg, change_next;
    logic                 first_reg,  first_next;
    logic [MAX_NODES-1:0] heard_reg,  heard_next;
    logic [MAX_NODES-1:0] nh_vld_reg, nh_vld_next;
    logic [IDX_W-1:0]     self_reg,   self_next;
    logic [CNT_W-1:0]     n_reg,      n_next;

    logic                 result_valid_reg, result_valid_next;
    logic [ID_W-1:0]      dest_node_reg,    dest_node_next;
    logic [COST_W-1:0]    distance_reg,     distance_next;
    logic [ID_W-1:0]      next_hop_reg,     next_hop_next;
    logic                 advertise_reg,    advertise_next;
    logic                 last_route_reg,   last_route_next;

    logic [TBL_AW-1:0]    own_raddr;
    logic [COST_W-1:0]    own_rdata;
    logic                 tbl_we;
    logic [TBL_AW-1:0]    tbl_waddr, tbl_raddr;
    logic [COST_W-1:0]    tbl_wdata, tbl_rdata;
    logic                 nh_we;
    logic [IDX_W-1:0]     nh_waddr, nh_raddr;
    logic [ID_W-1:0]      nh_wdata, nh_rdata;

    logic                 accept;
    logic                 src_ok, tgt_ok;
    logic [IDX_W-1:0]     src_idx, tgt_idx, i_idx, j_idx, p_idx;
    logic [COST_W-1:0]    cost_norm;
    logic [COST_W-1:0]    sum;
    logic [COST_W-2:0]    sat;
    logic                 relax;
    logic [6:0]           mod_v;

    // Both copies of the cost table take every write, so the own row entry and a
    // neighbor element can be read in the same cycle. The own row is the row at self.
    dvru_ram #(.WIDTH(COST_W), .DEPTH(TBL_DEPTH)) u_own_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    dvru_ram #(.WIDTH(COST_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    dvru_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_nh_ram (
        .clk   (clk),
        .we    (nh_we),
        .waddr (nh_waddr),
        .wdata (nh_wdata),
        .raddr (nh_raddr),
        .rdata (nh_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign src_ok    = int'(source_node) < MAX_NODES;
    assign tgt_ok    = int'(target_node) < MAX_NODES;
    assign src_idx   = IDX_W'(source_node);
    assign tgt_idx   = IDX_W'(target_node);
    assign i_idx     = IDX_W'(i_reg);
    assign j_idx     = IDX_W'(j_reg);
    assign p_idx     = IDX_W'(p_j_reg);
    assign cost_norm = cost[COST_W-1] ? COST_UNREACH : cost;

    // Relaxation of one element: own[i] + cost[i][j], saturated, against own[j].
    assign sum   = {1'b0, di_reg} + {1'b0, tbl_rdata[COST_W-2:0]};
    assign sat   = sum[COST_W-1] ? COST_SAT : sum[COST_W-2:0];
    assign relax = p_vld_reg && !p_out_reg && !tbl_rdata[COST_W-1]
                   && (own_rdata[COST_W-1] || (own_rdata[COST_W-2:0] > sat));

    // self_id modulo MAX_NODES by repeated subtraction on a narrow value.
    always_comb
    begin
        mod_v = 7'(cfg_data[ID_W-1:0]);
        for (int k = 0; k < 8; k++)
        begin
            if (mod_v >= 7'(MAX_NODES))
            begin
                mod_v = mod_v - 7'(MAX_NODES);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        p_j_next          = p_j_reg;
        p_vld_next        = 1'b0;
        p_out_next        = p_out_reg;
        di_next           = di_reg;
        change_next       = change_reg;
        first_next        = first_reg;
        heard_next        = heard_reg;
        nh_vld_next       = nh_vld_reg;
        self_next         = self_reg;
        n_next            = n_reg;
        result_valid_next = 1'b0;
        dest_node_next    = dest_node_reg;
        distance_next     = distance_reg;
        next_hop_next     = next_hop_reg;
        advertise_next    = advertise_reg;
        last_route_next   = last_route_reg;

        own_raddr = '0;
        tbl_we    = 1'b0;
        tbl_waddr = {src_idx, tgt_idx};
        tbl_wdata = cost_norm;
        tbl_raddr = '0;
        nh_we     = 1'b0;
        nh_waddr  = '0;
        nh_wdata  = '0;
        nh_raddr  = '0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SELF_ID:    self_next = IDX_W'(mod_v);
                REG_NODE_COUNT: n_next = (cfg_data > CNT_W'(N_LIM)) ? CNT_W'(N_LIM) : cfg_data;
                default:        n_next = n_reg;
            endcase
        end

        // Only one of the following writers is active in any cycle: transfers
        // are taken in idle, relaxation writes come from the running walk.
        if (accept)
        begin
            if (func == FUNC_LINK)
            begin
                if (tgt_ok)
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = {self_reg, tgt_idx};
                end
            end
            else if (src_ok)
            begin
                if (tgt_ok)
                begin
                    tbl_we = 1'b1;
                end
                if (last_element)
                begin
                    first_next          = !heard_reg[src_idx];
                    heard_next[src_idx] = 1'b1;
                    change_next         = 1'b0;
                    nh_we               = 1'b1;
                    nh_waddr            = self_reg;
                    nh_wdata            = ID_W'(self_reg);
                    nh_vld_next[self_reg] = 1'b1;
                    i_next              = '0;
                    state_next          = S_ROW;
                end
            end
        end

        if (relax)
        begin
            tbl_we             = 1'b1;
            tbl_waddr          = {self_reg, p_idx};
            tbl_wdata          = {1'b0, sat};
            nh_we              = 1'b1;
            nh_waddr           = p_idx;
            nh_wdata           = i_reg[ID_W-1:0];
            nh_vld_next[p_idx] = 1'b1;
            change_next        = 1'b1;
        end

        if (p_vld_reg && p_out_reg)
        begin
            result_valid_next = 1'b1;
            dest_node_next    = p_j_reg[ID_W-1:0];
            distance_next     = own_rdata;
            next_hop_next     = nh_vld_reg[p_idx] ? nh_rdata : p_j_reg[ID_W-1:0];
            advertise_next    = change_reg || first_reg;
            last_route_next   = (CNT_W'(p_j_reg + 1'b1) == n_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_ROW:
            begin
                if (i_reg >= n_reg)
                begin
                    j_next     = '0;
                    state_next = (n_reg == '0) ? S_IDLE : S_OUT;
                end
                else if (!heard_reg[i_idx] || (i_idx == self_reg))
                begin
                    i_next = CNT_W'(i_reg + 1'b1);
                end
                else
                begin
                    own_raddr  = {self_reg, i_idx};
                    state_next = S_DI;
                end
            end
            S_DI:
            begin
                // An unreachable neighbor relaxes nothing in its row.
                if (own_rdata[COST_W-1])
                begin
                    i_next     = CNT_W'(i_reg + 1'b1);
                    state_next = S_ROW;
                end
                else
                begin
                    di_next    = own_rdata[COST_W-2:0];
                    j_next     = '0;
                    state_next = S_COL;
                end
            end
            S_COL:
            begin
                tbl_raddr  = {i_idx, j_idx};
                own_raddr  = {self_reg, j_idx};
                p_vld_next = 1'b1;
                p_out_next = 1'b0;
                p_j_next   = j_reg;
                if (CNT_W'(j_reg + 1'b1) == n_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = CNT_W'(j_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                i_next     = CNT_W'(i_reg + 1'b1);
                state_next = S_ROW;
            end
            S_OUT:
            begin
                own_raddr  = {self_reg, j_idx};
                nh_raddr   = j_idx;
                p_vld_next = 1'b1;
                p_out_next = 1'b1;
                p_j_next   = j_reg;
                if (CNT_W'(j_reg + 1'b1) == n_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    j_next = CNT_W'(j_reg + 1'b1);
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            p_vld_reg        <= 1'b0;
            p_out_reg        <= 1'b0;
            change_reg       <= 1'b0;
            first_reg        <= 1'b0;
            heard_reg        <= '0;
            nh_vld_reg       <= '0;
            self_reg         <= '0;
            n_reg            <= CNT_W'(N_LIM);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            p_vld_reg        <= p_vld_next;
            p_out_reg        <= p_out_next;
            change_reg       <= change_next;
            first_reg        <= first_next;
            heard_reg        <= heard_next;
            nh_vld_reg       <= nh_vld_next;
            self_reg         <= self_next;
            n_reg            <= n_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_j_reg        <= p_j_next;
        di_reg         <= di_next;
        dest_node_reg  <= dest_node_next;
        distance_reg   <= distance_next;
        next_hop_reg   <= next_hop_next;
        advertise_reg  <= advertise_next;
        last_route_reg <= last_route_next;
    end

    assign result_valid = result_valid_reg;
    assign dest_node    = dest_node_reg;
    assign distance     = distance_reg;
    assign next_hop     = next_hop_reg;
    assign advertise    = advertise_reg;
    assign last_route   = last_route_reg;

endmodule

@@ rtl/core/dvru_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module dvru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ test/distance_vector_route_update_unit_tb.sv @@
// Self-checking testbench for the distance-vector route update unit.
`timescale 1ns / 1ps

module distance_vector_route_update_unit_tb;

    import dvru_pkg::*;

    typedef struct {
        logic                     op;
        logic [ID_W-1:0]          src;
        logic [ID_W-1:0]          tgt;
        logic signed [COST_W-1:0] cost_raw;
        logic                     last;
        bit                       hold;
    } vec_item_t;

    typedef struct {
        logic [ID_W-1:0]          dest;
        logic signed [COST_W-1:0] route_dist;
        logic [ID_W-1:0]          hop;
        logic                     adv;
        logic                     is_last;
    } route_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [REG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     func = FUNC_LINK;
    logic [ID_W-1:0]          source_node = '0;
    logic [ID_W-1:0]          target_node = '0;
    logic signed [COST_W-1:0] cost = '0;
    logic                     last_element = 1'b0;
    logic                     result_valid;
    logic [ID_W-1:0]          dest_node;
    logic signed [COST_W-1:0] distance;
    logic [ID_W-1:0]          next_hop;
    logic                     advertise;
    logic                     last_route;

    distance_vector_route_update_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .source_node  (source_node),
        .target_node  (target_node),
        .cost         (cost),
        .last_element (last_element),
        .result_valid (result_valid),
        .dest_node    (dest_node),
        .distance     (distance),
        .next_hop     (next_hop),
        .advertise    (advertise),
        .last_route   (last_route)
    );

    // Predicted copy of the block's tables and registers.
    logic signed [COST_W-1:0] cost_mem [DVRU_MAX_NODES][DVRU_MAX_NODES];
    bit                       heard_row [DVRU_MAX_NODES];
    logic [ID_W-1:0]          hop_mem [DVRU_MAX_NODES];
    logic [ID_W-1:0]          my_id = '0;
    logic [CNT_W-1:0]         node_limit = CNT_W'(DVRU_MAX_NODES);

    // Which table entries the queued stimulus has written, and which rows it has completed.
    bit gen_written [DVRU_MAX_NODES][DVRU_MAX_NODES];
    bit gen_heard [DVRU_MAX_NODES];

    vec_item_t pending_items[$];
    route_t    expected_routes[$];
    vec_item_t on_port;
    vec_item_t staged;
    route_t    want_route;
    int        idle_left = 0;
    bit        sender_gaps_on = 1'b1;
    int        mismatch_count = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    task automatic predict_routes(input vec_item_t it);
        logic signed [COST_W-1:0] stored;
        logic [ID_W-1:0]          row;
        int                       n;
        int                       path_cost;
        bit                       first_vec;
        bit                       changed;
        route_t                   r;
        stored = it.cost_raw[COST_W-1] ? COST_UNREACH : it.cost_raw;
        row = (it.op == FUNC_LINK) ? my_id : it.src;
        cost_mem[row][it.tgt] = stored;
        if (it.op == FUNC_LINK || !it.last)
            return;
        first_vec = !heard_row[it.src];
        heard_row[it.src] = 1'b1;
        n = (node_limit > DVRU_MAX_NODES) ? DVRU_MAX_NODES : int'(node_limit);
        changed = 1'b0;
        hop_mem[my_id] = my_id;
        // Relaxation runs in place, so later rows see the improvements of earlier ones.
        for (int i = 0; i < n; i++) begin
            if (!heard_row[i] || i == my_id)
                continue;
            for (int j = 0; j < n; j++) begin
                if (cost_mem[i][j] < 0 || cost_mem[my_id][i] < 0)
                    continue;
                path_cost = int'(cost_mem[my_id][i]) + int'(cost_mem[i][j]);
                if (path_cost > int'(COST_SAT))
                    path_cost = int'(COST_SAT);
                if (cost_mem[my_id][j] < 0 || cost_mem[my_id][j] > path_cost) begin
                    cost_mem[my_id][j] = COST_W'(path_cost);
                    hop_mem[j] = ID_W'(i);
                    changed = 1'b1;
                end
            end
        end
        for (int j = 0; j < n; j++) begin
            r.dest = ID_W'(j);
            r.route_dist = cost_mem[my_id][j];
            r.hop = hop_mem[j];
            r.adv = changed || first_vec;
            r.is_last = (j == n - 1);
            expected_routes.push_back(r);
        end
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 9))
            0: return COST_UNREACH;
            1: return '0;
            2, 3, 4: return COST_W'($urandom_range(1, 15));
            5, 6: return COST_W'($urandom_range(16, 400));
            7: return COST_W'($urandom_range(30000, 32767));
            8: return COST_W'($urandom);
            default: return {1'b0, COST_SAT};
        endcase
    endfunction

    function automatic int pick_target(input int n);
        return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
    endfunction

    task automatic push_item(input logic op, input int src, input int tgt,
                             input logic [COST_W-1:0] c, input logic last, input bit hold);
        vec_item_t it;
        it.op = op;
        it.src = ID_W'(src);
        it.tgt = ID_W'(tgt);
        it.cost_raw = c;
        it.last = last;
        it.hold = hold;
        if (op == FUNC_LINK) begin
            gen_written[my_id][it.tgt] = 1'b1;
        end else begin
            gen_written[it.src][it.tgt] = 1'b1;
            if (last)
                gen_heard[it.src] = 1'b1;
        end
        pending_items.push_back(it);
    endtask

    // A run reads the own row and every heard neighbor row below n, so any entry there that
    // was never written gets a cost first.
    task automatic cover_reads(input int src);
        int n;
        n = int'(node_limit);
        for (int j = 0; j < n; j++)
            if (!gen_written[my_id][j])
                push_item(FUNC_LINK, $urandom_range(0, 15), j, pick_cost(), 1'b0, 1'b0);
        for (int i = 0; i < n; i++) begin
            if (!(gen_heard[i] || i == src) || i == my_id)
                continue;
            for (int j = 0; j < n; j++)
                if (!gen_written[i][j])
                    push_item(FUNC_VECTOR, i, j, pick_cost(), 1'b0, 1'b0);
        end
    endtask

    task automatic add_item(input logic op, input int src, input int tgt,
                            input logic [COST_W-1:0] c, input logic last, input bit hold);
        if (op == FUNC_VECTOR && last)
            cover_reads(src);
        push_item(op, src, tgt, c, last, hold);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_SELF_ID)
            my_id = val[ID_W-1:0];
        else
            node_limit = val;
    endtask

    // Sampled on the falling edge so that the driver's updates at the rising edge are settled.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || expected_routes.size() != 0);
        repeat (8) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic gen_random(input int how_many);
        int made;
        int n;
        int src;
        int len;
        int kind;
        made = 0;
        n = int'(node_limit);
        while (made < how_many) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // Mostly complete vectors in order; a few wander outside the table in use.
                src = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, n - 1);
                len = $urandom_range(1, n);
                for (int k = 0; k < len; k++)
                    add_item(FUNC_VECTOR, src, ($urandom_range(0, 3) == 0) ? pick_target(n) : k,
                             pick_cost(), k == len - 1, k == 0 && $urandom_range(0, 19) == 0);
                made += len;
            end else if (kind <= 7) begin
                add_item(FUNC_LINK, $urandom_range(0, 15), pick_target(n), pick_cost(),
                         $urandom_range(0, 1), 1'b0);
                made++;
            end else if (kind == 8) begin
                add_item(FUNC_VECTOR, $urandom_range(0, 15), $urandom_range(0, 15),
                         pick_cost(), 1'b0, 1'b0);
                made++;
            end else begin
                add_item(FUNC_VECTOR, $urandom_range(0, n - 1), pick_target(n), pick_cost(),
                         1'b1, 1'b0);
                made++;
            end
        end
    endtask

    task automatic run_phase(input int self_node, input int nodes, input int how_many,
                             input bit gaps);
        write_reg(REG_SELF_ID, CFG_W'(self_node));
        write_reg(REG_NODE_COUNT, CFG_W'(nodes));
        sender_gaps_on = gaps;
        gen_random(how_many);
        drain();
    endtask

    // Driver: presents one item at a time and predicts it at the edge that accepts it.
    always @(posedge clk) begin
        if (rst_n && !(start && busy)) begin
            if (start)
                predict_routes(on_port);
            if (idle_left != 0) begin
                idle_left <= idle_left - 1;
                start <= 1'b0;
            end else if (pending_items.size() == 0 ||
                         (pending_items[0].hold && expected_routes.size() != 0)) begin
                start <= 1'b0;
            end else if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
                idle_left <= $urandom_range(0, 16);
                start <= 1'b0;
            end else begin
                staged = pending_items.pop_front();
                on_port <= staged;
                func <= staged.op;
                source_node <= staged.src;
                target_node <= staged.tgt;
                cost <= staged.cost_raw;
                last_element <= staged.last;
                start <= 1'b1;
            end
        end
    end

    // Monitor: every route entry transfer is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && result_valid) begin
            if (expected_routes.size() == 0) begin
                report_failure($sformatf("unexpected route entry: dest %0d dist %0d hop %0d",
                                         dest_node, distance, next_hop));
            end else begin
                want_route = expected_routes.pop_front();
                if (dest_node !== want_route.dest || distance !== want_route.route_dist ||
                    next_hop !== want_route.hop || advertise !== want_route.adv ||
                    last_route !== want_route.is_last)
                    report_failure($sformatf({"route mismatch: expected dest %0d dist %0d ",
                                              "hop %0d adv %0b last %0b, got dest %0d ",
                                              "dist %0d hop %0d adv %0b last %0b"},
                        want_route.dest, want_route.route_dist, want_route.hop,
                        want_route.adv, want_route.is_last, dest_node, distance, next_hop,
                        advertise, last_route));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < DVRU_MAX_NODES; i++) begin
            heard_row[i] = 1'b0;
            gen_heard[i] = 1'b0;
            hop_mem[i] = ID_W'(i);
            for (int j = 0; j < DVRU_MAX_NODES; j++) begin
                cost_mem[i][j] = '0;
                gen_written[i][j] = 1'b0;
            end
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on a four-node table seen from node 2.
        write_reg(REG_SELF_ID, CFG_W'(2));
        write_reg(REG_NODE_COUNT, CFG_W'(4));
        add_item(FUNC_LINK, 0, 0, 16'd5, 1'b0, 1'b0);
        add_item(FUNC_LINK, 9, 1, COST_UNREACH, 1'b0, 1'b0);
        add_item(FUNC_LINK, 0, 2, 16'd0, 1'b0, 1'b0);
        add_item(FUNC_LINK, 0, 3, 16'h7FFF, 1'b0, 1'b0);
        // A link write ignores the last flag; a cost with the sign bit set counts as no link.
        add_item(FUNC_LINK, 15, 15, 16'h8000, 1'b1, 1'b0);
        add_item(FUNC_VECTOR, 0, 0, 16'd0, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 0, 1, 16'd3, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 0, 2, 16'd5, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 0, 3, COST_UNREACH, 1'b1, 1'b0);
        // The same vector again changes nothing and is not the first, so no advertisement.
        add_item(FUNC_VECTOR, 0, 3, COST_UNREACH, 1'b1, 1'b0);
        add_item(FUNC_VECTOR, 1, 0, 16'd2, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 1, 1, 16'd0, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 1, 2, 16'd4, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 1, 3, 16'd1, 1'b1, 1'b0);
        // A vector from this node itself lands in the own row and is skipped by relaxation.
        add_item(FUNC_VECTOR, 2, 1, 16'd1, 1'b1, 1'b0);
        add_item(FUNC_LINK, 0, 1, COST_UNREACH, 1'b0, 1'b0);
        add_item(FUNC_LINK, 0, 3, 16'h7FFF, 1'b0, 1'b0);
        add_item(FUNC_LINK, 0, 0, 16'h7FFF, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 3, 0, 16'd100, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 3, 1, 16'h7FFF, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 3, 2, 16'd1, 1'b0, 1'b0);
        add_item(FUNC_VECTOR, 3, 3, 16'd0, 1'b1, 1'b0);
        // Neighbor outside the nodes in use; held back until the table has settled.
        add_item(FUNC_VECTOR, 15, 15, 16'h7FFF, 1'b1, 1'b1);
        drain();

        run_phase(0, 1, 6, 1'b1);
        run_phase(15, 16, 10, 1'b1);
        run_phase(5, 7, 8, 1'b1);
        run_phase(9, 3, 8, 1'b0);

        repeat (40) @(posedge clk);
        if (expected_routes.size() != 0)
            report_failure($sformatf("%0d route entries never arrived",
                                     expected_routes.size()));
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
